### src/pcbs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the plate character box selector
// no dependencies; used by the top level and its checker

package pcbs_pkg;

    localparam int FIELD_W = 10;
    localparam int BOX_W   = 4 * FIELD_W;
    localparam int Q_W     = 8;

    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
    localparam logic [FIELD_W-1:0] PW_RESET  = 10'd136;
    localparam logic [Q_W-1:0]     Q_RESET   = Q_W'(136 / 7);

    // floor(pw / 7) = (pw * 1171) >> 13 for pw < 1024
    localparam logic [10:0] Q7_MULT  = 11'd1171;
    localparam int          Q7_SHIFT = 13;

    // widening: floor(w*23/20) = floor((w*23 >> 2) / 5), /5 by 13108 >> 16
    localparam logic [4:0]  WIDE_MULT  = 5'd23;
    localparam logic [13:0] DIV5_MULT  = 14'd13108;
    localparam int          DIV5_SHIFT = 16;

    // shift: floor(w*529/400) = floor((w*529 >> 4) / 25), /25 by 41944 >> 20
    localparam logic [9:0]  SHIFT_MULT  = 10'd529;
    localparam logic [15:0] DIV25_MULT  = 16'd41944;
    localparam int          DIV25_SHIFT = 20;

    localparam logic [2:0] WANT_NORMAL = 3'd6;
    localparam logic [2:0] WANT_NEW_EN = 3'd7;

    typedef struct packed {
        logic [FIELD_W-1:0] h;
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] x;
    } t_box;

endpackage

### src/pcbs_ram.sv
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module pcbs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/plate_char_box_selector.sv
`timescale 1ns / 1ps
// Plate character box selector. Boxes of one plate, sorted left to right, are
// taken one per cycle into a box memory while the largest width and height are
// tracked; a box that arrives with the memory full is dropped. The transfer that
// carries tlast starts selection: the memory is read back one entry per cycle
// to find the special box, the leading box is derived in the states S_LEAD_RD,
// S_LEAD_MUL, S_LEAD_DIV and S_LEAD_OUT, and each stored box that follows needs
// a memory read in S_EMIT_RD and an output load in S_EMIT_WAIT; no box of the
// next plate is taken until the last box has been loaded for output. The single
// memory read port sets this pace. plate_width may be written whenever no plate
// is in progress.
// depends on pcbs_pkg and pcbs_ram

module plate_char_box_selector #(
    parameter int MAX_BOXES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // box_x, box_y, box_width, box_height from bit 0 up
    input  logic [pcbs_pkg::BOX_W-1:0]   i_s_tdata,
    input  logic                         i_s_tlast,   // last_box
    input  logic                         i_s_tuser,   // new_energy
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // out_x, out_y, out_width, out_height from bit 0 up
    output logic [pcbs_pkg::BOX_W-1:0]   o_m_tdata,
    output logic                         o_m_tlast,   // last_out
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // plate_width
    input  logic [pcbs_pkg::FIELD_W-1:0] i_cfg_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready
);

    localparam int ADDR_W = $clog2(MAX_BOXES);
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam int SUM_W  = CNT_W + 3;
    localparam int FW     = pcbs_pkg::FIELD_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_LEAD_RD,
        S_LEAD_MUL,
        S_LEAD_DIV,
        S_LEAD_OUT,
        S_EMIT_RD,
        S_EMIT_WAIT
    } t_state;

    t_state r_state;

    logic [CNT_W-1:0]           r_count;
    logic [FW-1:0]              r_widest;
    logic [FW-1:0]              r_tallest;
    logic [pcbs_pkg::Q_W-1:0]   r_q;
    logic                       r_new_en;
    logic [CNT_W-1:0]           r_ri;
    logic                       r_chk;
    logic [ADDR_W-1:0]          r_chk_idx;
    logic [ADDR_W-1:0]          r_sel;
    logic [CNT_W-1:0]           r_end;
    logic [CNT_W-1:0]           r_idx;
    logic [FW-1:0]              r_lx;
    logic [FW-1:0]              r_ly;
    logic [FW-1:0]              r_lh;
    logic [14:0]                r_p23;
    logic [19:0]                r_p529;
    logic [FW:0]                r_nw;
    logic [FW:0]                r_sh;
    pcbs_pkg::t_box             r_m_data;
    logic                       r_m_last;
    logic                       r_m_valid;

    logic                       w_s_fire;
    logic                       w_has_room;
    logic                       w_out_free;
    logic                       w_m_load;
    logic                       w_rd_en;
    logic [ADDR_W-1:0]          w_rd_addr;
    pcbs_pkg::t_box             w_in_box;
    pcbs_pkg::t_box             w_rd_box;
    logic [pcbs_pkg::BOX_W-1:0] w_rd_data;
    logic [20:0]                w_q_prod;
    logic [12:0]                w_w5;
    logic [12:0]                w_h5;
    logic [12:0]                w_widest4;
    logic [12:0]                w_tallest4;
    logic [FW:0]                w_mid;
    logic [FW:0]                w_q_lo;
    logic [FW:0]                w_q_hi;
    logic                       w_hit;
    logic [26:0]                w_div5;
    logic [31:0]                w_div25;
    logic [SUM_W-1:0]           w_sum;
    logic [CNT_W-1:0]           w_end;
    logic [FW-1:0]              w_lead_w;
    logic [FW-1:0]              w_lead_x;
    logic [FW:0]                w_x_diff;

    assign w_in_box    = pcbs_pkg::t_box'(i_s_tdata);
    assign w_rd_box    = pcbs_pkg::t_box'(w_rd_data);
    assign o_s_tready  = (r_state == S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign w_s_fire    = i_s_tvalid && o_s_tready;
    assign w_has_room  = (r_count < CNT_W'(MAX_BOXES));
    assign w_out_free  = !r_m_valid || i_m_tready;
    // output register loads a new box in these states
    assign w_m_load    = w_out_free && ((r_state == S_LEAD_OUT) || (r_state == S_EMIT_WAIT));

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_sel;
        unique case (r_state)
            S_SCAN: begin
                w_rd_en   = (r_ri < r_count);
                w_rd_addr = r_ri[ADDR_W-1:0];
            end
            S_LEAD_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_sel;
            end
            S_EMIT_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_idx[ADDR_W-1:0];
            end
            default: begin
                w_rd_en   = 1'b0;
                w_rd_addr = r_sel;
            end
        endcase
    end

    pcbs_ram #(
        .WIDTH (pcbs_pkg::BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_s_fire && w_has_room),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (i_s_tdata),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // centre window q = plate_width / 7, worked out when the register is written
    assign w_q_prod = 21'(i_cfg_data) * 21'(pcbs_pkg::Q7_MULT);

    // size test against 0.8 of the maxima, done as 5*w > 4*max
    assign w_w5       = 13'(w_rd_box.w) * 13'd5;
    assign w_h5       = 13'(w_rd_box.h) * 13'd5;
    assign w_widest4  = {1'b0, r_widest, 2'b00};
    assign w_tallest4 = {1'b0, r_tallest, 2'b00};
    assign w_mid      = {1'b0, w_rd_box.x} + {2'b00, w_rd_box.w[FW-1:1]};
    assign w_q_lo     = (FW+1)'(r_q);
    assign w_q_hi     = (FW+1)'({r_q, 1'b0});
    assign w_hit      = ((w_w5 > w_widest4) || (w_h5 > w_tallest4))
                        && (w_mid > w_q_lo) && (w_mid < w_q_hi);

    assign w_div5  = 27'(r_p23[14:2]) * 27'(pcbs_pkg::DIV5_MULT);
    assign w_div25 = 32'(r_p529[19:4]) * 32'(pcbs_pkg::DIV25_MULT);

    assign w_sum = SUM_W'(r_sel)
                   + SUM_W'(r_new_en ? pcbs_pkg::WANT_NEW_EN : pcbs_pkg::WANT_NORMAL);
    assign w_end = (w_sum > SUM_W'(r_count)) ? r_count : w_sum[CNT_W-1:0];

    assign w_lead_w = (r_nw > (FW+1)'(pcbs_pkg::FIELD_MAX)) ? pcbs_pkg::FIELD_MAX
                                                             : r_nw[FW-1:0];
    assign w_x_diff = {1'b0, r_lx} - r_sh;
    assign w_lead_x = ({1'b0, r_lx} > r_sh) ? w_x_diff[FW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_widest  <= '0;
            r_tallest <= '0;
            r_q       <= pcbs_pkg::Q_RESET;
            r_chk     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_q <= pcbs_pkg::Q_W'(w_q_prod >> pcbs_pkg::Q7_SHIFT);
            end
            if (w_m_load) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (w_s_fire) begin
                        if (w_has_room) begin
                            r_count <= r_count + CNT_W'(1);
                            if (w_in_box.w > r_widest) begin
                                r_widest <= w_in_box.w;
                            end
                            if (w_in_box.h > r_tallest) begin
                                r_tallest <= w_in_box.h;
                            end
                        end
                        if (i_s_tlast) begin
                            r_new_en <= i_s_tuser;
                            r_ri     <= '0;
                            r_chk    <= 1'b0;
                            r_sel    <= '0;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // the read issued for an entry is tested in the next cycle
                    if (r_chk && w_hit) begin
                        r_sel <= r_chk_idx;
                    end
                    if (r_ri < r_count) begin
                        r_ri      <= r_ri + CNT_W'(1);
                        r_chk     <= 1'b1;
                        r_chk_idx <= r_ri[ADDR_W-1:0];
                    end else begin
                        r_chk <= 1'b0;
                        if (!r_chk) begin
                            r_state <= S_LEAD_RD;
                        end
                    end
                end
                S_LEAD_RD: begin
                    r_end   <= w_end;
                    r_state <= S_LEAD_MUL;
                end
                S_LEAD_MUL: begin
                    r_lx    <= w_rd_box.x;
                    r_ly    <= w_rd_box.y;
                    r_lh    <= w_rd_box.h;
                    r_p23   <= 15'(w_rd_box.w) * 15'(pcbs_pkg::WIDE_MULT);
                    r_p529  <= 20'(w_rd_box.w) * 20'(pcbs_pkg::SHIFT_MULT);
                    r_state <= S_LEAD_DIV;
                end
                S_LEAD_DIV: begin
                    r_nw    <= (FW+1)'(w_div5 >> pcbs_pkg::DIV5_SHIFT);
                    r_sh    <= (FW+1)'(w_div25 >> pcbs_pkg::DIV25_SHIFT);
                    r_state <= S_LEAD_OUT;
                end
                S_LEAD_OUT: begin
                    if (w_out_free) begin
                        r_m_data.x <= w_lead_x;
                        r_m_data.y <= r_ly;
                        r_m_data.w <= w_lead_w;
                        r_m_data.h <= r_lh;
                        r_m_last   <= (r_end <= CNT_W'(r_sel));
                        r_idx      <= CNT_W'(r_sel);
                        r_state    <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT: begin
                    if (w_out_free) begin
                        r_m_data  <= w_rd_box;
                        r_m_last  <= (r_idx + CNT_W'(1) == r_end);
                        if (r_idx + CNT_W'(1) == r_end) begin
                            r_count   <= '0;
                            r_widest  <= '0;
                            r_tallest <= '0;
                            r_state   <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;
    assign o_m_tvalid = r_m_valid;

endmodule

### src/pcbs_checker.sv
`timescale 1ns / 1ps
// port-level checks for the plate character box selector, bound to the top level
// depends on pcbs_pkg and plate_char_box_selector

module pcbs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tlast,
    input logic                         i_s_tvalid,
    input logic                         o_s_tready,
    input logic [pcbs_pkg::BOX_W-1:0]   o_m_tdata,
    input logic                         o_m_tlast,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic                         i_cfg_valid,
    input logic                         o_cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // the box that closes a plate starts selection, so input stops
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input taken right after last box");

    // a box that is not last never produces a result by itself
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid && o_s_tready |=> !o_m_tvalid)
        else $error("result appeared while loading");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("bad state after reset");

    // configuration is never back-pressured
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind plate_char_box_selector pcbs_checker u_pcbs_checker (.*);
